### rtl/core/stms_pkg.sv
package stms_pkg;

  // Default table depth
  localparam int unsigned CAPACITY_DEF = 1024;

  // Value width of one table entry
  localparam int unsigned VALUE_W = 32;

  // Operation codes of an input request
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

endpackage

### rtl/core/stms_ram.sv
module stms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/sorted_table_membership_search.sv
// Channel   Ports                                   Direction
// --------  --------------------------------------  ---------
// in        in_valid, in_stall, in_op, in_value     sink
// out       out_valid, out_stall, out_found,        source
//           out_dropped
//
// One request at a time. A query does a table read and a compare per halving
// step of the binary search, until the window is empty or the value is found.
// An insert does the same search, then moves each entry above its slot up by
// one, top first, and writes the new value. Clear resets the entry count.
// The loop is set by the registered read of the table RAM. Synchronous reset
// empties the table at once; no clearing pass. A new request is taken while a
// finished result waits under out_stall; the next result waits its turn.
module sorted_table_membership_search #(
  parameter int unsigned CAPACITY = stms_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_op,
  input  logic signed [stms_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_found,
  output logic                                out_dropped
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned VW = stms_pkg::VALUE_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_PROBE   = 3'd1;
  localparam logic [2:0] ST_COMPARE = 3'd2;
  localparam logic [2:0] ST_SHIFT   = 3'd3;
  localparam logic [2:0] ST_WRITE   = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic                 out_dropped_r, out_dropped_nxt;
  logic                 pend_r, pend_nxt;
  logic [1:0]           op_r, op_nxt;
  logic signed [VW-1:0] value_r, value_nxt;
  logic [CW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        hi_r, hi_nxt;
  logic [CW-1:0]        mid_r, mid_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [AW-1:0]        pend_addr_r, pend_addr_nxt;
  logic                 res_found_r, res_found_nxt;
  logic                 res_dropped_r, res_dropped_nxt;

  logic                 in_take;
  logic [CW-1:0]        mid_calc;
  logic [CW-1:0]        idx_m1;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [VW-1:0]        wr_data;
  logic [AW-1:0]        rd_addr;
  logic [VW-1:0]        rd_data;

  assign in_stall    = (state_r != ST_IDLE);
  assign in_take     = in_valid && !in_stall;
  assign out_valid   = out_valid_r;
  assign out_found   = out_found_r;
  assign out_dropped = out_dropped_r;

  // Midpoint of the search window and the shift pointer below idx
  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);
  assign idx_m1   = idx_r - CW'(1);

  stms_ram #(
    .WIDTH(VW),
    .DEPTH(CAPACITY)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Table port steering
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_addr_r;
    wr_data = rd_data;
    rd_addr = mid_calc[AW-1:0];
    unique case (state_r)
      ST_SHIFT: begin
        wr_en   = pend_r;
        rd_addr = idx_m1[AW-1:0];
      end
      ST_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = lo_r[AW-1:0];
        wr_data = value_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    out_valid_nxt   = out_valid_r;
    out_found_nxt   = out_found_r;
    out_dropped_nxt = out_dropped_r;
    pend_nxt        = 1'b0;
    op_nxt          = op_r;
    value_nxt       = value_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    mid_nxt         = mid_r;
    idx_nxt         = idx_r;
    pend_addr_nxt   = pend_addr_r;
    res_found_nxt   = res_found_r;
    res_dropped_nxt = res_dropped_r;

    // Result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          op_nxt          = in_op;
          value_nxt       = in_value;
          lo_nxt          = '0;
          hi_nxt          = count_r;
          res_found_nxt   = 1'b0;
          res_dropped_nxt = 1'b0;
          priority if (in_op == stms_pkg::OP_INSERT) begin
            if (count_r >= CW'(CAPACITY)) begin
              res_dropped_nxt = 1'b1;
              state_nxt       = ST_DONE;
            end else begin
              state_nxt = ST_PROBE;
            end
          end else if (in_op == stms_pkg::OP_QUERY) begin
            state_nxt = ST_PROBE;
          end else if (in_op == stms_pkg::OP_CLEAR) begin
            count_nxt = '0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end

      // Issue a table read at the midpoint, or end the search
      ST_PROBE: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_calc;
          state_nxt = ST_COMPARE;
        end else if (op_r == stms_pkg::OP_INSERT) begin
          idx_nxt   = count_r;
          state_nxt = ST_SHIFT;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      // Signed compare of the probe against the request value
      ST_COMPARE: begin
        if (op_r == stms_pkg::OP_QUERY && $signed(rd_data) == value_r) begin
          res_found_nxt = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          if ($signed(rd_data) > value_r) begin
            hi_nxt = mid_r;
          end else begin
            lo_nxt = mid_r + CW'(1);
          end
          state_nxt = ST_PROBE;
        end
      end

      // Move entries [lo, count) up by one, top first: read now, write next
      ST_SHIFT: begin
        if (idx_r > lo_r) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = idx_r[AW-1:0];
          idx_nxt       = idx_m1;
        end else begin
          state_nxt = ST_WRITE;
        end
      end

      // Place the new value in its slot
      ST_WRITE: begin
        count_nxt = count_r + CW'(1);
        state_nxt = ST_DONE;
      end

      // Hand the result over when the output register is free
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_found_nxt   = res_found_r;
          out_dropped_nxt = res_dropped_r;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_found_r   <= out_found_nxt;
    out_dropped_r <= out_dropped_nxt;
    op_r          <= op_nxt;
    value_r       <= value_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    mid_r         <= mid_nxt;
    idx_r         <= idx_nxt;
    pend_addr_r   <= pend_addr_nxt;
    res_found_r   <= res_found_nxt;
    res_dropped_r <= res_dropped_nxt;
  end

endmodule
